[src/sbmc_pkg.sv]
package sbmc_pkg;

    localparam int unsigned SAMPLE_W    = 32;
    localparam int unsigned WINDOW_W    = 16;
    localparam int unsigned DATA_W      = 31;
    localparam int unsigned FORMAT_W    = 2;
    localparam int unsigned DEF_BLOCK_FRAMES = 192;
    localparam int unsigned M_TDATA_W   = 64;

    localparam logic [31:0] PREAMBLE_B = 32'h3317_3333;
    localparam logic [31:0] PREAMBLE_M = 32'h331d_3333;
    localparam logic [31:0] PREAMBLE_W = 32'h331b_3333;

    typedef enum logic [FORMAT_W-1:0] {
        FMT_16 = 2'd0,
        FMT_24 = 2'd1,
        FMT_32 = 2'd2
    } sample_format_t;

    // biphase-mark cells of one byte, msb first in the code word
    function automatic logic [15:0] cell_code(input logic [7:0] x);
        logic [15:0] code;
        logic        second;
        logic        first;
        code   = '0;
        second = 1'b1;
        for (int k = 7; k >= 0; k--) begin
            first           = second ^ x[k];
            code[14 - 2*k]  = second;
            code[15 - 2*k]  = first;
            second          = ~first;
        end
        return code;
    endfunction

endpackage

[src/sbmc_data_enc.sv]
module sbmc_data_enc
    import sbmc_pkg::*;
(
    input  logic [SAMPLE_W-1:0] sample,
    input  logic [FORMAT_W-1:0] sample_format,
    output logic [DATA_W-1:0]   data_word
);

    logic [WINDOW_W-1:0] window;
    logic [15:0]         code_lo;
    logic [15:0]         code_hi;
    logic [31:0]         word;

    always_comb begin
        case (sample_format)
            FMT_24:  window = sample[23:8];
            FMT_32:  window = sample[31:16];
            default: window = sample[15:0];
        endcase
    end

    assign code_lo   = cell_code(window[7:0]);
    assign code_hi   = cell_code(window[15:8]);
    assign word      = {code_lo, 16'h0000} ^ {{16{code_hi[15]}}, code_hi};
    assign data_word = word[DATA_W-1:0];

endmodule

[src/spdif_bmc_subframe_encoder_top.sv]
// S/PDIF biphase-mark subframe encoder. Each s_ transaction carries one PCM
// sample container and yields one m_ transaction holding the 32-bit preamble
// word and the 31-bit coded data word of that subframe; m_tlast marks the
// last subframe of each half block. The block takes one sample every cycle
// unless m_tready stalls its single result register; a new sample is taken in
// the same cycle a waiting result leaves. The user must write sample_format
// over the cfg_ port only while no transaction is in flight; the block does
// not enforce it. The subframe counter restarts at B preamble after reset.
module spdif_bmc_subframe_encoder_top
    import sbmc_pkg::*;
#(
    parameter int unsigned BLOCK_FRAMES = DEF_BLOCK_FRAMES
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [FORMAT_W-1:0]   cfg_data,     // sample_format
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [SAMPLE_W-1:0]   s_tdata,      // sample
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,      // preamble_word, data_word, zero pad
    output logic                  m_tlast       // half_block_end
);

    localparam int unsigned SUBFRAMES = 2 * BLOCK_FRAMES;
    localparam int unsigned IDX_W     = $clog2(SUBFRAMES);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(SUBFRAMES - 1);
    localparam logic [IDX_W-1:0] IDX_HALF = IDX_W'(BLOCK_FRAMES - 1);

    logic [FORMAT_W-1:0] format_reg;
    logic [IDX_W-1:0]    index_reg;
    logic [IDX_W-1:0]    index_next;
    logic                m_valid_reg;
    logic [31:0]         preamble_reg;
    logic [31:0]         preamble_next;
    logic [DATA_W-1:0]   data_reg;
    logic [DATA_W-1:0]   data_next;
    logic                last_reg;
    logic                last_next;
    logic                s_accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = ~m_valid_reg | m_tready;
    assign s_accept  = s_tvalid & s_tready;

    sbmc_data_enc u_data_enc (
        .sample        (s_tdata),
        .sample_format (format_reg),
        .data_word     (data_next)
    );

    always_comb begin
        if (index_reg == '0) begin
            preamble_next = PREAMBLE_B;
        end else if (!index_reg[0]) begin
            preamble_next = PREAMBLE_M;
        end else begin
            preamble_next = PREAMBLE_W;
        end
        last_next  = (index_reg == IDX_HALF) || (index_reg == IDX_LAST);
        index_next = (index_reg >= IDX_LAST) ? '0 : index_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            format_reg  <= FMT_16;
            index_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                format_reg <= cfg_data;
            end
            if (s_accept) begin
                index_reg   <= index_next;
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            preamble_reg <= preamble_next;
            data_reg     <= data_next;
            last_reg     <= last_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, data_reg, preamble_reg};
    assign m_tlast  = last_reg;

endmodule

[tb/sv/spdif_bmc_subframe_encoder_top_tb.sv]
module spdif_bmc_subframe_encoder_top_tb
    import sbmc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAMES      = DEF_BLOCK_FRAMES;
    localparam logic [1:0]  FMT_UNUSED  = 2'd3;
    localparam int          CYCLE_LIMIT = 200000;
    localparam int          BATCH_ITEMS = 184;
    localparam int          HOLD_AT     = 900;
    localparam int          HOLD_CYCLES = 300;

    typedef struct packed {
        logic [31:0] preamble;
        logic [30:0] data;
        logic        last;
    } subframe_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [FORMAT_W-1:0]  cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [SAMPLE_W-1:0]  s_tdata   = '0;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;

    logic [31:0]    sample_q[$];
    subframe_t      subframe_q[$];
    logic [1:0]     fmt_reg   = FMT_16;
    logic [8:0]     frame_idx = '0;
    int             tx_idle_pct = 0;
    int             rx_idle_pct = 0;
    int             errors    = 0;
    int             n_results = 0;
    int             hold_cnt  = 0;
    bit             hold_done = 1'b0;
    int             cycles    = 0;

    spdif_bmc_subframe_encoder_top #(
        .BLOCK_FRAMES(FRAMES)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #4 aclk = ~aclk;

    // cell i pair holds data bit 7-i, second cell in the low position
    function automatic logic [15:0] bmc_byte(input logic [7:0] b);
        logic [15:0] cells;
        logic        lvl;
        logic        head;
        cells = '0;
        lvl   = 1'b1;
        for (int i = 0; i < 8; i++) begin
            head           = lvl ^ b[7-i];
            cells[2*i]     = lvl;
            cells[2*i+1]   = head;
            lvl            = ~head;
        end
        return cells;
    endfunction

    function automatic subframe_t encode_subframe(input logic [31:0] smp,
                                                  input logic [1:0] fmt,
                                                  input logic [8:0] idx);
        subframe_t   sf;
        logic [15:0] win;
        logic [15:0] el;
        logic [15:0] eh;
        logic [31:0] word;
        case (fmt)
            FMT_24:  win = smp[23:8];
            FMT_32:  win = smp[31:16];
            default: win = smp[15:0];
        endcase
        el   = bmc_byte(win[7:0]);
        eh   = bmc_byte(win[15:8]);
        word = {el, 16'h0000} ^ {{16{eh[15]}}, eh};
        sf.data = word[30:0];
        if (idx == 9'd0)
            sf.preamble = PREAMBLE_B;
        else if (!idx[0])
            sf.preamble = PREAMBLE_M;
        else
            sf.preamble = PREAMBLE_W;
        sf.last = (idx == FRAMES - 1) || (idx == 2 * FRAMES - 1);
        return sf;
    endfunction

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                subframe_q.push_back(encode_subframe(s_tdata, fmt_reg, frame_idx));
                if (frame_idx >= 2 * FRAMES - 1)
                    frame_idx = '0;
                else
                    frame_idx = frame_idx + 9'd1;
            end
            if (!s_tvalid || s_tready) begin
                if (sample_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_q.pop_front();
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        subframe_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (subframe_q.size() == 0) begin
                    $error("unexpected transaction: tdata %h tlast %b", m_tdata, m_tlast);
                    errors++;
                end else begin
                    want = subframe_q.pop_front();
                    if (m_tdata[31:0] !== want.preamble) begin
                        $error("preamble_word: expected %h actual %h",
                               want.preamble, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[63:32] !== {1'b0, want.data}) begin
                        $error("data_word: expected %h actual %h",
                               {1'b0, want.data}, m_tdata[63:32]);
                        errors++;
                    end
                    if (m_tlast !== want.last) begin
                        $error("half_block_end: expected %b actual %b",
                               want.last, m_tlast);
                        errors++;
                    end
                end
                n_results++;
            end
            if (!hold_done && n_results >= HOLD_AT) begin
                hold_done = 1'b1;
                hold_cnt  = HOLD_CYCLES;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        @(negedge aclk);
        while (sample_q.size() > 0 || s_tvalid || subframe_q.size() > 0)
            @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_format(input logic [1:0] fmt);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= fmt;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        fmt_reg = fmt;
        @(negedge aclk);
    endtask

    task automatic load_random(input int n, input logic [1:0] fmt);
        logic [31:0] r;
        logic [31:0] wmask;
        int          sel;
        case (fmt)
            FMT_24:  wmask = 32'h00FF_FF00;
            FMT_32:  wmask = 32'hFFFF_0000;
            default: wmask = 32'h0000_FFFF;
        endcase
        for (int i = 0; i < n; i++) begin
            r   = $urandom;
            sel = $urandom_range(7);
            if (sel == 0)
                r = r & ~wmask;
            else if (sel == 1)
                r = r | wmask;
            sample_q.push_back(r);
        end
    endtask

    initial begin
        logic [31:0] wfull [4];
        logic [1:0]  rnd_fmt [6];
        wfull   = '{32'h0000_FFFF, 32'h00FF_FF00, 32'hFFFF_0000, 32'hFFFF_0000};
        rnd_fmt = '{FMT_32, FMT_24, FMT_16, FMT_UNUSED, FMT_32, FMT_16};

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // directed: window extremes and patterns in every format code
        tx_idle_pct = 23;
        rx_idle_pct = 82;
        for (int f = 0; f < 4; f++) begin
            write_format(f[1:0]);
            sample_q.push_back(32'h0000_0000);
            sample_q.push_back(32'hFFFF_FFFF);
            sample_q.push_back(32'h5555_5555);
            sample_q.push_back(32'hAAAA_AAAA);
            sample_q.push_back(32'h1234_5678);
            sample_q.push_back(~wfull[f]);
            wait_drained();
        end

        for (int b = 0; b < 6; b++) begin
            if (b < 2) begin
                tx_idle_pct = 23;
                rx_idle_pct = 82;
            end else if (b < 4) begin
                tx_idle_pct = 82;
                rx_idle_pct = 23;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_format(rnd_fmt[b]);
            load_random(BATCH_ITEMS, rnd_fmt[b]);
            wait_drained();
        end

        repeat (10) @(negedge aclk);
        if (errors == 0 && subframe_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
